/* src/lssd_pkg.sv */
// Shared types and constants for the LSB stego stream decoder.
// No dependencies; imported by the top level.
package lssd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_MAGIC      = 3'd1,
    PH_EXT_LEN    = 3'd2,
    PH_EXT_BYTES  = 3'd3,
    PH_DATA_LEN   = 3'd4,
    PH_DATA_BYTES = 3'd5,
    PH_IDLE       = 3'd6
  } phase_t;

  localparam logic [2:0] KIND_EXT_LEN   = 3'd0;
  localparam logic [2:0] KIND_EXT_BYTE  = 3'd1;
  localparam logic [2:0] KIND_DATA_LEN  = 3'd2;
  localparam logic [2:0] KIND_DATA_BYTE = 3'd3;
  localparam logic [2:0] KIND_MISMATCH  = 3'd4;

  localparam logic [1:0] CFG_HEADER_SKIP  = 2'd0;
  localparam logic [1:0] CFG_MAGIC_LENGTH = 2'd1;
  localparam logic [1:0] CFG_MAGIC_VALUE  = 2'd2;

  localparam logic [15:0] HEADER_SKIP_RST  = 16'd54;
  localparam logic [3:0]  MAGIC_LENGTH_RST = 4'd2;
  localparam logic [63:0] MAGIC_VALUE_RST  = 64'd8994;

  localparam logic [3:0] SIG_MAX_LEN = 4'd8;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] image_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [31:0] out_value;
    logic        last_of_run;
  } out_item_t;

endpackage

/* src/lsb_stego_stream_decoder.sv */
// Top level of the LSB stego stream decoder: parser state, config registers
// and a result register with a one-entry skid stage. Depends on lssd_pkg.
//
// Usage:
//   in_valid/in_stall/in_data carry one carrier byte per transfer, with
//   frame_start marking the first byte of an image. out_valid/out_stall/
//   out_data deliver decoded lengths, bytes and a signature mismatch code.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write header_skip (0),
//   magic_length (1) and magic_value (2); cfg_ready is always high.
// Output: a result is registered in the result register, or in the skid
//   stage if that is stalled, once the byte that completes it is accepted.
// Throughput: one byte per cycle while in_stall is low; each byte is a shift
//   and counter update done in one pass between state and result registers.
// Stall: a result blocked by out_stall stays and the next goes to the skid
//   stage; in_stall goes high only while that stage is full, so none is lost.
// Reset: rst_n (synchronous, active low) restores the config defaults,
//   empties both output stages and puts the parser in header skip.
module lsb_stego_stream_decoder import lssd_pkg::*; #(
  parameter int LENGTH_FIELD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int LFB   = LENGTH_FIELD_BITS;
  localparam int CNT_W = $clog2(LFB);

  logic [15:0]      header_skip_r;
  logic [3:0]       magic_length_r;
  logic [63:0]      magic_value_r;

  phase_t           phase_r, phase_nxt;
  logic [15:0]      header_count_r, header_count_nxt;
  logic [CNT_W-1:0] bit_count_r, bit_count_nxt;
  logic [LFB-1:0]   bit_shift_r, bit_shift_nxt;
  logic [3:0]       sig_index_r, sig_index_nxt;
  logic [LFB-1:0]   remaining_r, remaining_nxt;

  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  out_item_t        skid_data_r, skid_data_nxt;

  logic             in_accept;
  logic             out_take;
  logic             res_valid;
  out_item_t        res;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_skip_r  <= HEADER_SKIP_RST;
      magic_length_r <= MAGIC_LENGTH_RST;
      magic_value_r  <= MAGIC_VALUE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEADER_SKIP:  header_skip_r  <= cfg_data[15:0];
        CFG_MAGIC_LENGTH: magic_length_r <= cfg_data[3:0];
        CFG_MAGIC_VALUE:  magic_value_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parser step for one accepted byte.
  always_comb begin
    phase_t         ph;
    logic [15:0]    hc;
    logic [CNT_W-1:0] bc;
    logic [LFB-1:0] bs;
    logic [3:0]     si;
    logic [LFB-1:0] rc;
    logic           done;
    logic [3:0]     sig_len;
    logic [CNT_W:0] need;
    logic [2:0]     pos;
    logic [7:0]     want;

    phase_nxt        = phase_r;
    header_count_nxt = header_count_r;
    bit_count_nxt    = bit_count_r;
    bit_shift_nxt    = bit_shift_r;
    sig_index_nxt    = sig_index_r;
    remaining_nxt    = remaining_r;
    res_valid        = 1'b0;
    res              = '0;

    sig_len = (magic_length_r > SIG_MAX_LEN) ? SIG_MAX_LEN : magic_length_r;
    done    = 1'b0;
    need    = '0;
    pos     = '0;
    want    = '0;

    // restart parse on frame start
    ph = in_data.frame_start ? PH_HEADER : phase_r;
    hc = in_data.frame_start ? '0 : header_count_r;
    bc = in_data.frame_start ? '0 : bit_count_r;
    bs = in_data.frame_start ? '0 : bit_shift_r;
    si = in_data.frame_start ? '0 : sig_index_r;
    rc = in_data.frame_start ? '0 : remaining_r;

    if (in_accept) begin
      if (ph == PH_HEADER) begin
        if (hc < header_skip_r) begin
          hc   = hc + 16'd1;
          done = 1'b1;
        end else begin
          ph = PH_MAGIC;
        end
      end
      if (!done) begin
        if (ph == PH_MAGIC && si >= sig_len) ph = PH_EXT_LEN;
        if (ph != PH_IDLE) begin
          need = (ph == PH_EXT_LEN || ph == PH_DATA_LEN) ?
                 (CNT_W+1)'(LFB) : (CNT_W+1)'(8);
          bs = {bs[LFB-2:0], in_data.image_byte[0]};
          if (({1'b0, bc} + 1'b1) < need) begin
            bc = bc + 1'b1;
          end else begin
            bc = '0;
            case (ph)
              PH_MAGIC: begin
                pos  = 3'(sig_len - 4'd1 - si);
                want = magic_value_r[{pos, 3'b000} +: 8];
                if (bs[7:0] != want) begin
                  ph        = PH_IDLE;
                  res_valid = 1'b1;
                  res       = '{out_kind: KIND_MISMATCH, out_value: '0,
                                last_of_run: 1'b0};
                end else begin
                  si = si + 4'd1;
                  if (si >= sig_len) ph = PH_EXT_LEN;
                end
                bs = '0;
              end
              PH_EXT_LEN, PH_DATA_LEN: begin
                res_valid = 1'b1;
                res = '{out_kind: (ph == PH_EXT_LEN) ? KIND_EXT_LEN : KIND_DATA_LEN,
                        out_value: 32'(bs), last_of_run: 1'b0};
                // negative lengths count as empty runs
                rc = bs[LFB-1] ? '0 : bs;
                if (rc == '0) ph = (ph == PH_EXT_LEN) ? PH_DATA_LEN : PH_IDLE;
                else          ph = (ph == PH_EXT_LEN) ? PH_EXT_BYTES : PH_DATA_BYTES;
                bs = '0;
              end
              PH_EXT_BYTES, PH_DATA_BYTES: begin
                res_valid = 1'b1;
                res = '{out_kind: (ph == PH_EXT_BYTES) ? KIND_EXT_BYTE : KIND_DATA_BYTE,
                        out_value: {24'd0, bs[7:0]},
                        last_of_run: (rc <= LFB'(1))};
                if (rc != '0) rc = rc - 1'b1;
                if (rc == '0) ph = (ph == PH_EXT_BYTES) ? PH_DATA_LEN : PH_IDLE;
                bs = '0;
              end
              default: ;
            endcase
          end
        end
      end
      phase_nxt        = ph;
      header_count_nxt = hc;
      bit_count_nxt    = bc;
      bit_shift_nxt    = bs;
      sig_index_nxt    = si;
      remaining_nxt    = rc;
    end
  end

  // Result register plus skid stage.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_take) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (res_valid) begin
      if (!out_valid_r || (out_take && !skid_valid_r)) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        // hold the new result behind the stalled one
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      header_count_r <= '0;
      bit_count_r    <= '0;
      bit_shift_r    <= '0;
      sig_index_r    <= '0;
      remaining_r    <= '0;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      bit_count_r    <= bit_count_nxt;
      bit_shift_r    <= bit_shift_nxt;
      sig_index_r    <= sig_index_nxt;
      remaining_r    <= remaining_nxt;
      out_valid_r    <= out_valid_nxt;
      skid_valid_r   <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

/* bench/tb.sv */
// Self-checking bench for lsb_stego_stream_decoder: directed frames, then random
// frames under random stalls. Predicts results in a scoreboard class; needs lssd_pkg.
module tb;
  import lssd_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int LEN_BITS    = 32;

  // Shadow copy of the decoder: config, parse state and the results still owed.
  class stego_scoreboard;
    logic [15:0] skip;
    logic [3:0]  mlen;
    logic [63:0] mval;
    phase_t      ph;
    logic [15:0] hcount;
    logic [4:0]  bcount;
    logic [31:0] shreg;
    logic [3:0]  sidx;
    logic [31:0] remain;
    out_item_t   owed[$];
    int          errors;

    function new();
      skip   = HEADER_SKIP_RST;
      mlen   = MAGIC_LENGTH_RST;
      mval   = MAGIC_VALUE_RST;
      errors = 0;
      restart();
    endfunction

    function void restart();
      ph     = PH_HEADER;
      hcount = '0;
      bcount = '0;
      shreg  = '0;
      sidx   = '0;
      remain = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] d);
      case (idx)
        CFG_HEADER_SKIP:  skip = d[15:0];
        CFG_MAGIC_LENGTH: mlen = d[3:0];
        CFG_MAGIC_VALUE:  mval = d;
        default: ;
      endcase
    endfunction

    function void owe(logic [2:0] kind, logic [31:0] value, logic last);
      out_item_t r;
      r.out_kind    = kind;
      r.out_value   = value;
      r.last_of_run = last;
      owed.push_back(r);
    endfunction

    function void note_byte(in_item_t it);
      logic [3:0]  slen;
      logic [2:0]  pos;
      logic [7:0]  want;
      logic [31:0] raw;
      int          need;
      slen = (mlen > SIG_MAX_LEN) ? SIG_MAX_LEN : mlen;
      if (it.frame_start) restart();
      if (ph == PH_HEADER) begin
        if (hcount < skip) begin
          hcount = hcount + 16'd1;
          return;
        end
        ph = PH_MAGIC;
      end
      if (ph == PH_MAGIC && sidx >= slen) ph = PH_EXT_LEN;
      if (ph == PH_IDLE) return;
      need  = (ph == PH_EXT_LEN || ph == PH_DATA_LEN) ? LEN_BITS : 8;
      shreg = {shreg[30:0], it.image_byte[0]};
      if (int'(bcount) + 1 < need) begin
        bcount = bcount + 5'd1;
        return;
      end
      bcount = '0;
      case (ph)
        PH_MAGIC: begin
          pos   = 3'(slen - 4'd1 - sidx);
          want  = mval[8*pos +: 8];
          raw   = shreg;
          shreg = '0;
          if (raw[7:0] != want) begin
            ph = PH_IDLE;
            owe(KIND_MISMATCH, '0, 1'b0);
            return;
          end
          sidx = sidx + 4'd1;
          if (sidx >= slen) ph = PH_EXT_LEN;
        end
        PH_EXT_LEN, PH_DATA_LEN: begin
          raw    = shreg;
          shreg  = '0;
          remain = raw[LEN_BITS-1] ? '0 : raw;
          owe((ph == PH_EXT_LEN) ? KIND_EXT_LEN : KIND_DATA_LEN, raw, 1'b0);
          if (remain == 0) ph = (ph == PH_EXT_LEN) ? PH_DATA_LEN : PH_IDLE;
          else ph = phase_t'(ph + 3'd1);
        end
        default: begin
          raw   = {24'd0, shreg[7:0]};
          shreg = '0;
          owe((ph == PH_EXT_BYTES) ? KIND_EXT_BYTE : KIND_DATA_BYTE, raw, remain <= 1);
          if (remain > 0) remain = remain - 32'd1;
          if (remain == 0) ph = (ph == PH_EXT_BYTES) ? PH_DATA_LEN : PH_IDLE;
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        $error("unexpected result kind %0d value %0h", got.out_kind, got.out_value);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.out_kind !== want.out_kind) begin
        $error("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind);
        errors++;
      end
      if (got.out_value !== want.out_value) begin
        $error("out_value: expected %0h, got %0h", want.out_value, got.out_value);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  stego_scoreboard sb = new();
  bit calm;
  int hid_items;
  int cycles;

  lsb_stego_stream_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_byte(in_data);
    end
  end

  // Mostly short gaps, a few long ones; none in calm stretches.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly short runs; some with the sign bit set, some too long to finish.
  function automatic logic [31:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 75) return $urandom_range(1, 4);
    if (r < 85) return {1'b1, 31'($urandom)};
    if (r < 92) return {1'b0, 31'($urandom)};
    return $urandom_range(5, 12);
  endfunction

  function automatic void push_bits(ref bit q[$], input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) q.push_back(v[i]);
  endfunction

  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  // Present one byte and hold it until the transfer.
  task automatic push_byte(input bit fs, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{frame_start: fs, image_byte: b};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_frame(input bit with_start, input bit bad_sig, input bit cut,
                            input logic [31:0] ext_len, input logic [31:0] data_len);
    bit         hid[$];
    logic [3:0] slen;
    logic [7:0] ch;
    logic [7:0] b;
    int         bad_at;
    int         nbytes;
    int         keep;
    bit         first;
    bit         trunc;
    trunc  = cut;
    slen   = (sb.mlen > SIG_MAX_LEN) ? SIG_MAX_LEN : sb.mlen;
    bad_at = (bad_sig && slen != 0) ? $urandom_range(0, int'(slen) - 1) : -1;
    for (int i = 0; i < int'(slen); i++) begin
      ch = sb.mval[8*(int'(slen) - 1 - i) +: 8];
      if (i == bad_at) ch = ch ^ (8'h01 << $urandom_range(0, 7));
      push_bits(hid, {24'd0, ch}, 8);
    end
    push_bits(hid, ext_len, LEN_BITS);
    nbytes = ext_len[31] ? 0 : (ext_len > 16 ? 16 : int'(ext_len));
    if (!ext_len[31] && ext_len > 16) trunc = 1'b1;
    for (int i = 0; i < nbytes; i++) push_bits(hid, {24'd0, pick_byte()}, 8);
    push_bits(hid, data_len, LEN_BITS);
    nbytes = data_len[31] ? 0 : (data_len > 16 ? 16 : int'(data_len));
    if (!data_len[31] && data_len > 16) trunc = 1'b1;
    for (int i = 0; i < nbytes; i++) push_bits(hid, {24'd0, pick_byte()}, 8);
    if (trunc) begin
      keep = $urandom_range(0, hid.size() - 1);
      while (hid.size() > keep) void'(hid.pop_back());
    end
    first = with_start;
    for (int i = 0; i < int'(sb.skip); i++) begin
      push_byte(first, 8'($urandom));
      first = 1'b0;
    end
    foreach (hid[i]) begin
      b    = 8'($urandom);
      b[0] = hid[i];
      push_byte(first, b);
      first = 1'b0;
    end
    // Trailing bytes are dropped once the frame is done.
    repeat ($urandom_range(0, 4)) push_byte(1'b0, 8'($urandom));
    hid_items += hid.size();
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) push_byte($urandom_range(0, 7) == 0, 8'($urandom));
    hid_items += n;
  endtask

  // Drain all owed results, then give the pipeline time to empty.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [63:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_config(input logic [15:0] skip, input logic [3:0] mlen,
                             input logic [63:0] mval);
    write_cfg(CFG_HEADER_SKIP, {48'd0, skip});
    write_cfg(CFG_MAGIC_LENGTH, {60'd0, mlen});
    write_cfg(CFG_MAGIC_VALUE, mval);
  endtask

  initial begin
    int r;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm      = 1'b0;
    hid_items = 0;
    cycles    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset config, no frame start: empty extension run, one data byte.
    send_frame(1'b0, 1'b0, 1'b0, 32'd0, 32'd1);
    settle();

    // No header, no signature, negative lengths.
    load_config(16'd0, 4'd0, 64'd0);
    send_frame(1'b1, 1'b0, 1'b0, 32'h8000_0003, 32'd2);
    send_frame(1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'd0);
    settle();

    // Signature length above the maximum, mismatch, restart mid-frame.
    load_config(16'd1, 4'd15, {$urandom, $urandom});
    send_frame(1'b1, 1'b0, 1'b0, 32'd1, 32'd1);
    send_frame(1'b1, 1'b1, 1'b0, 32'd1, 32'd1);
    send_frame(1'b1, 1'b0, 1'b1, 32'd2, 32'd2);
    send_frame(1'b1, 1'b0, 1'b0, 32'd2, 32'h7FFF_FFFF);
    settle();

    // Long header, full signature of all ones.
    calm = 1'b1;
    load_config(16'd100, 4'd8, '1);
    send_frame(1'b1, 1'b0, 1'b0, 32'd1, 32'd1);
    settle();

    do begin
      calm = ($urandom_range(0, 3) == 0);
      r    = $urandom_range(0, 9);
      load_config((r == 0) ? 16'd0 : 16'($urandom_range(0, 6)),
                  4'($urandom_range(0, 15)),
                  (r == 1) ? '1 : (r == 2) ? '0 : {$urandom, $urandom});
      repeat (4) begin
        r = $urandom_range(0, 99);
        if (r < 70) send_frame(1'b1, 1'b0, 1'b0, pick_len(), pick_len());
        else if (r < 80) send_frame(1'b1, 1'b1, 1'b0, pick_len(), pick_len());
        else if (r < 90) send_frame(1'b1, 1'b0, 1'b1, pick_len(), pick_len());
        else send_noise($urandom_range(10, 40));
      end
      settle();
    end while (hid_items < 800);

    repeat (8) @(posedge clk);
    if (sb.owed.size() != 0) begin
      $error("%0d expected results never arrived", sb.owed.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
